@@ hw/rtl/skt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table package
// Item types, operation and status codes, and control types shared by the
// cells, the search unit and the top level.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int KEY_W    = 32;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 6;
   localparam int COUNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type             op;
      logic signed [KEY_W-1:0] key;
   } cell_ctrl_type;

   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_flags_type;

   typedef struct packed {
      logic load;
      logic step;
      logic stop_on_equal;
   } srch_ctrl_type;

   typedef struct packed {
      logic done;
      logic found;
   } srch_stat_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_COMPARE,
      S_SEARCH,
      S_UPDATE,
      S_RESPOND
   } state_type;

endpackage
`default_nettype wire

@@ hw/rtl/skt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table cell
// Holds one key, shifts toward either neighbor on insert or delete, and
// registers its comparison against the current item's key.
// ----------------------------------------------------------------------------
module skt_cell #(
   parameter int INDEX = 0,
   parameter int IDX_W = 6
) (
   input  logic                             clock,
   input  skt_pkg::cell_ctrl_type           ctrl,
   input  logic [IDX_W-1:0]                 upd_pos,
   input  logic signed [skt_pkg::KEY_W-1:0] key_left,
   input  logic signed [skt_pkg::KEY_W-1:0] key_right,
   output logic signed [skt_pkg::KEY_W-1:0] key_out,
   output skt_pkg::cmp_flags_type           flags_out
);
   import skt_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] key_in;
   cmp_flags_type           flags_ff;
   cmp_flags_type           flags_in;

   always_comb begin
      key_in = key_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (MY_IDX > upd_pos) begin
               key_in = key_left;
            end else if (MY_IDX == upd_pos) begin
               key_in = ctrl.key;
            end
         end
         CELL_DELETE: begin
            if (MY_IDX >= upd_pos) begin
               key_in = key_right;
            end
         end
         default: begin
            key_in = key_ff;
         end
      endcase
   end

   always_comb begin
      flags_in.gt = key_ff > ctrl.key;
      flags_in.eq = key_ff == ctrl.key;
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      flags_ff <= flags_in;
   end

   assign key_out   = key_ff;
   assign flags_out = flags_ff;

endmodule
`default_nettype wire

@@ hw/rtl/skt_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table search unit
// Binary search over the cells' registered compare flags, one probe per cycle.
// ----------------------------------------------------------------------------
module skt_search #(
   parameter int DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  skt_pkg::srch_ctrl_type         ctrl,
   input  logic [$clog2(DEPTH+1)-1:0]     count,
   input  logic [DEPTH-1:0]               gt_vec,
   input  logic [DEPTH-1:0]               eq_vec,
   output skt_pkg::srch_stat_type         stat,
   output logic [$clog2(DEPTH)-1:0]       pos
);
   import skt_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   // The window is [lo, hi); hi is exclusive so that an empty table needs no
   // negative bound.
   logic [CW-1:0] lo_ff;
   logic [CW-1:0] lo_in;
   logic [CW-1:0] hi_ff;
   logic [CW-1:0] hi_in;
   logic [CW:0]   mid_sum;
   logic [IW-1:0] mid;
   logic          active;
   logic          hit;

   always_comb begin
      active  = lo_ff < hi_ff;
      mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - (CW+1)'(1);
      mid     = mid_sum[IW:1];
      hit     = ctrl.stop_on_equal && active && eq_vec[mid];
      stat.done  = !active || hit;
      stat.found = hit;
      pos        = hit ? mid : lo_ff[IW-1:0];
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (ctrl.load) begin
         lo_in = '0;
         hi_in = count;
      end else if (ctrl.step && !stat.done) begin
         if (gt_vec[mid]) begin
            hi_in = CW'(mid);
         end else begin
            lo_in = CW'(mid) + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '0;
         hi_ff <= '0;
      end else begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/sorted_key_table_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted key table
// Ascending table of signed keys held in a row of cells, with insert, search
// and delete commands.
// ----------------------------------------------------------------------------
//  Channel   Ports                  Handshake
//  request   start, busy, req_data  item taken when start is high, busy low
//  response  rsp_valid, rsp_data    one-cycle strobe, cannot be held off
//
// An item passes through a compare state, a search state that repeats until the
// search is done, a shift state for an insert or a found delete, and a response
// state; the block then returns to idle before it takes the next item.
// Each search cycle probes one cell's registered compare flags.
// A full-table insert or an unknown command goes from the compare state straight to the response state.
// Reset empties the table at once; the receiver cannot stall the block.
// ----------------------------------------------------------------------------
module sorted_key_table_top #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  skt_pkg::req_type req_data,
   output logic             rsp_valid,
   output skt_pkg::rsp_type rsp_data
);
   import skt_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH+1);

   state_type           state_ff;
   state_type           state_in;
   req_type             req_ff;
   req_type             req_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [IDX_W-1:0]    pos_ff;
   logic [IDX_W-1:0]    pos_in;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;

   cell_ctrl_type           cell_ctrl;
   logic signed [KEY_W-1:0] cell_key [TABLE_DEPTH];
   cmp_flags_type           cell_flags [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  gt_vec;
   logic [TABLE_DEPTH-1:0]  eq_vec;
   srch_ctrl_type           srch_ctrl;
   srch_stat_type           srch_stat;
   logic [IDX_W-1:0]        srch_pos;
   logic                    table_full;
   logic                    cmd_known;
   logic                    is_insert;

   assign table_full = count_ff == CNT_W'(TABLE_DEPTH);
   assign is_insert  = req_ff.command == CMD_INSERT;
   assign cmd_known  = (req_ff.command == CMD_INSERT) || (req_ff.command == CMD_SEARCH)
                       || (req_ff.command == CMD_DELETE);

   genvar i;
   generate
      for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         logic signed [KEY_W-1:0] left_key;
         logic signed [KEY_W-1:0] right_key;
         if (i == 0) begin : g_first
            assign left_key = cell_ctrl.key;
         end else begin : g_left
            assign left_key = cell_key[i-1];
         end
         if (i == TABLE_DEPTH-1) begin : g_last
            assign right_key = cell_ctrl.key;
         end else begin : g_right
            assign right_key = cell_key[i+1];
         end
         skt_cell #(
            .INDEX (i),
            .IDX_W (IDX_W)
         ) u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .upd_pos   (pos_ff),
            .key_left  (left_key),
            .key_right (right_key),
            .key_out   (cell_key[i]),
            .flags_out (cell_flags[i])
         );
         assign gt_vec[i] = cell_flags[i].gt;
         assign eq_vec[i] = cell_flags[i].eq;
      end
   endgenerate

   skt_search #(
      .DEPTH (TABLE_DEPTH)
   ) u_search (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (srch_ctrl),
      .count  (count_ff),
      .gt_vec (gt_vec),
      .eq_vec (eq_vec),
      .stat   (srch_stat),
      .pos    (srch_pos)
   );

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            if ((is_insert && table_full) || !cmd_known) begin
               state_in = S_RESPOND;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (srch_stat.done) begin
               if (is_insert || (srch_stat.found && req_ff.command == CMD_DELETE)) begin
                  state_in = S_UPDATE;
               end else begin
                  state_in = S_RESPOND;
               end
            end
         end
         S_UPDATE: begin
            state_in = S_RESPOND;
         end
         S_RESPOND: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin : outputs
      busy                    = 1'b1;
      rsp_valid               = 1'b0;
      req_in                  = req_ff;
      status_in               = status_ff;
      pos_in                  = pos_ff;
      count_in                = count_ff;
      srch_ctrl.load          = 1'b0;
      srch_ctrl.step          = 1'b0;
      srch_ctrl.stop_on_equal = !is_insert;
      cell_ctrl.op            = CELL_HOLD;
      cell_ctrl.key           = req_ff.key;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               req_in = req_data;
            end
         end
         S_COMPARE: begin
            srch_ctrl.load = 1'b1;
            pos_in         = '0;
            status_in      = (is_insert && table_full) ? STATUS_FULL : STATUS_OK;
         end
         S_SEARCH: begin
            srch_ctrl.step = 1'b1;
            if (srch_stat.done) begin
               if (is_insert || srch_stat.found) begin
                  pos_in = srch_pos;
               end else begin
                  status_in = STATUS_NOT_FOUND;
                  pos_in    = '0;
               end
            end
         end
         S_UPDATE: begin
            if (is_insert) begin
               cell_ctrl.op = CELL_INSERT;
               count_in     = count_ff + CNT_W'(1);
            end else begin
               cell_ctrl.op = CELL_DELETE;
               count_in     = count_ff - CNT_W'(1);
            end
         end
         S_RESPOND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_data.status   = status_ff;
      rsp_data.position = POS_W'(pos_ff);
      rsp_data.count    = COUNT_W'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("Fill count exceeds table depth.");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Response strobe lasted more than one cycle.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Block not busy after taking an item.");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_FULL) |-> table_full)
      else $error("Full status reported on a table with free room.");

   a_update_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |=> (count_ff != $past(count_ff)))
      else $error("Shift cycle did not change the fill count.");
`endif

endmodule
`default_nettype wire
